FILE: sv/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press repeat.
package bdlp_pkg;

    // Configuration registers are 16 bits wide.
    localparam int REG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_PRESS_TICKS = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REPEAT_TICKS     = 1'd1;

    // Debounced phase of one button.
    localparam logic [1:0] PH_RELEASED = 2'd0;
    localparam logic [1:0] PH_PRESSED  = 2'd1;
    localparam logic [1:0] PH_LONG     = 2'd2;

    // Effective timing values, already clamped to their legal minimum.
    typedef struct packed {
        logic [REG_WIDTH-1:0] long_thr;    // count at which button 0 goes long held
        logic [REG_WIDTH-1:0] repeat_len;  // ticks between repeat events
    } bdlp_cfg_t;

    // Per-button result of one tick.
    typedef struct packed {
        logic press;
        logic rep_evt;
        logic held;
        logic long_held;
    } bdlp_status_t;

endpackage

FILE: sv/bdlp_cell.sv
// One button: three-sample debounce, press counter, and phase tracking.
module bdlp_cell
    import bdlp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter bit HAS_LONG    = 1'b0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         advance,
    input  logic         level,
    input  bdlp_cfg_t    cfg,
    output bdlp_status_t status
);

    localparam int CMP_W = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

    logic [2:0]             hist_reg, hist_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [1:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       count_cmp;
    logic                   first;
    logic                   rep;

    assign hist_next = {hist_reg[1:0], level};
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_WIDTH'(1);
    assign count_cmp = CMP_W'(count_inc);

    always_comb begin
        count_next = count_reg;
        phase_next = phase_reg;
        first      = 1'b0;
        rep        = 1'b0;
        if (hist_next == 3'b111) begin
            count_next = '0;
            phase_next = PH_RELEASED;
        end else if (hist_next == 3'b000) begin
            first      = (phase_reg == PH_RELEASED);
            count_next = count_inc;
            if (HAS_LONG) begin
                if (phase_reg == PH_LONG) begin
                    if (count_cmp >= CMP_W'(cfg.repeat_len)) begin
                        rep        = 1'b1;
                        count_next = '0;
                    end
                end else if (count_cmp >= CMP_W'(cfg.long_thr)) begin
                    // Threshold reached: enter long held, repeat fires instead
                    // of the press event even on the very first press tick.
                    phase_next = PH_LONG;
                    rep        = 1'b1;
                    count_next = '0;
                    first      = 1'b0;
                end else begin
                    phase_next = PH_PRESSED;
                end
            end else begin
                phase_next = PH_PRESSED;
                count_next = COUNT_WIDTH'(2);
            end
        end
    end

    assign status.press     = first;
    assign status.rep_evt   = rep;
    assign status.held      = (phase_next != PH_RELEASED);
    assign status.long_held = (phase_next == PH_LONG);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= 3'b111;
            count_reg <= '0;
            phase_reg <= PH_RELEASED;
        end else if (advance) begin
            hist_reg  <= hist_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: sv/button_debounce_long_press.sv
// Top level of the multi-button debouncer with long-press auto-repeat.
//
//  Channel   Direction  Payload (lowest bits first)
//  -------   ---------  ------------------------------------------------------
//  s_axis    in         raw_levels[NUM_BUTTONS] (0 = pressed)
//  m_axis    out        press_events[NUM_BUTTONS], repeat_event,
//                       held_buttons[NUM_BUTTONS], long_held
//  cfg       in         index 0: long_press_ticks, index 1: repeat_ticks
//
// Each input transaction is one tick. It is captured in an input register, the
// per-button update runs as shallow logic between that register and the output
// register, and one result transaction follows per tick. m_tvalid rises when the
// tick moves from the input register into the output register, and a new
// transaction is accepted every cycle unless both registers are full and stalled.
// When m_tready is low the output register holds; the input register keeps
// accepting until it is also occupied, then s_tready drops. Reset (synchronous,
// active low) empties both registers, marks every button released with three
// released samples, and restores long_press_ticks to 100 and repeat_ticks to 20.
module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = 5,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // raw_levels[NUM_BUTTONS-1:0], zero padded to whole bytes.
    input  logic [((NUM_BUTTONS+7)/8)*8-1:0]       s_tdata,
    // Result stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // press_events[NUM_BUTTONS], repeat_event, held_buttons[NUM_BUTTONS],
    // long_held, zero padded to whole bytes.
    output logic [((2*NUM_BUTTONS+2+7)/8)*8-1:0]   m_tdata,
    // Configuration write port.
    input  logic                                   cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]             cfg_index,
    input  logic [REG_WIDTH-1:0]                   cfg_data
);

    localparam int OUT_W       = 2 * NUM_BUTTONS + 2;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int REP_BIT     = NUM_BUTTONS;
    localparam int HELD_LSB    = NUM_BUTTONS + 1;
    localparam int LONG_BIT    = 2 * NUM_BUTTONS + 1;

    // Configuration registers.
    logic [REG_WIDTH-1:0] long_press_ticks_reg;
    logic [REG_WIDTH-1:0] repeat_ticks_reg;
    bdlp_cfg_t            cfg_eff;

    // Input register.
    logic                   s1_valid_reg;
    logic [NUM_BUTTONS-1:0] s1_levels_reg;

    // Output register.
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_data_reg;

    logic                   out_free;
    logic                   advance;
    bdlp_status_t           status [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] press_next;
    logic [NUM_BUTTONS-1:0] held_next;
    logic [OUT_W-1:0]       m_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_ticks_reg <= REG_WIDTH'(100);
            repeat_ticks_reg     <= REG_WIDTH'(20);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_data;
                CFG_REPEAT_TICKS:     repeat_ticks_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // A long-press setting below two acts as two, so the threshold count is
    // at least one; a repeat interval of zero acts as one.
    always_comb begin
        if (long_press_ticks_reg < REG_WIDTH'(2)) begin
            cfg_eff.long_thr = REG_WIDTH'(1);
        end else begin
            cfg_eff.long_thr = long_press_ticks_reg - REG_WIDTH'(1);
        end
        if (repeat_ticks_reg == '0) begin
            cfg_eff.repeat_len = REG_WIDTH'(1);
        end else begin
            cfg_eff.repeat_len = repeat_ticks_reg;
        end
    end

    // The input register moves on whenever the output register is empty or
    // is being drained in this cycle.
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_levels_reg <= s_tdata[NUM_BUTTONS-1:0];
        end
    end

    // Button 0 carries the long-press and repeat logic; the others only
    // debounce and report the first press.
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        bdlp_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .HAS_LONG    (i == 0)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .level   (s1_levels_reg[i]),
            .cfg     (cfg_eff),
            .status  (status[i])
        );
        assign press_next[i] = status[i].press;
        assign held_next[i]  = status[i].held;
    end

    assign m_data_next = {status[0].long_held, held_next, status[0].rep_evt, press_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_data_reg);

    // A repeat event only fires while button 0 is long held.
    a_repeat_needs_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[REP_BIT] |-> m_data_reg[LONG_BIT])
        else $error("repeat event without long-held state");

    // Long held implies button 0 is reported as held.
    a_long_implies_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[LONG_BIT] |-> m_data_reg[HELD_LSB])
        else $error("long held while button 0 not held");

    // A press event is only reported for a button that is now held.
    a_press_implies_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |->
            ((m_data_reg[NUM_BUTTONS-1:0] & ~m_data_reg[HELD_LSB +: NUM_BUTTONS]) == '0))
        else $error("press event for a button that is not held");

    // A tick waiting in the input register is not lost while the output stalls.
    a_input_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_levels_reg))
        else $error("pending tick dropped during output stall");

endmodule

FILE: dv/tb_button_debounce_long_press.sv
// Self-checking testbench for the five-button debouncer with long-press auto-repeat.
module tb_button_debounce_long_press;
    import bdlp_pkg::*;

    localparam int NB = 5;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_ITEMS = 165;

    // One result transaction. The member order makes the packed layout match m_tdata[11:0]:
    // press_events in the lowest bits, then repeat_event, held_buttons and long_held.
    typedef struct packed {
        logic       lng;
        logic [4:0] held;
        logic       rep;
        logic [4:0] press;
    } tick_res_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    // One line of the directed stimulus. A pinned row carries its expected result typed
    // in by hand; every other tick row is checked against the predictor.
    typedef struct {
        row_kind_t                  kind;
        logic [CFG_INDEX_WIDTH-1:0] idx;
        logic [15:0]                val;
        bit                         pinned;
        tick_res_t                  want;
    } dir_row_t;

    // Block ports. Every input is known from time zero.
    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata   = 8'h1F;   // raw_levels[4:0], zero padded
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [15:0]                m_tdata;             // press[4:0], rep, held[4:0], long
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [REG_WIDTH-1:0]       cfg_data  = '0;

    // Shadow copy of the block's state and registers, kept by the predictor.
    logic [2:0]  samp_hist [NB];
    logic [15:0] press_cnt [NB];
    logic [1:0]  btn_phase [NB];
    logic [15:0] lp_reg;
    logic [15:0] rp_reg;

    // Expected results in the order the block must deliver them.
    tick_res_t result_q[$];

    // A hand-typed expectation travels alongside the item that it belongs to.
    bit        pin_now = 1'b0;
    tick_res_t pin_res = '0;

    bit tx_idle   = 1'b1;
    bit rx_idle   = 1'b1;
    bit stall_req = 1'b0;
    int err_count = 0;

    always #5 aclk = ~aclk;

    button_debounce_long_press #(
        .NUM_BUTTONS(NB),
        .COUNT_WIDTH(16)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Advances the shadow state by one tick and returns the result that the tick causes.
    // Each button shifts its raw level into a three-sample history and changes its
    // debounced state only when all three samples agree.
    function automatic tick_res_t debounce_tick(logic [4:0] levels);
        tick_res_t r;
        logic [2:0] h;
        int c;
        int lp_eff;
        int rp_eff;
        bit first;
        r = '0;
        // Out-of-range register values are clamped to their legal minimum.
        lp_eff = (lp_reg < 16'd2) ? 2 : int'(lp_reg);
        rp_eff = (rp_reg == 16'd0) ? 1 : int'(rp_reg);
        for (int i = 0; i < NB; i++) begin
            h = {samp_hist[i][1:0], levels[i]};
            samp_hist[i] = h;
            if (h == 3'b111) begin
                press_cnt[i] = '0;
                btn_phase[i] = PH_RELEASED;
            end else if (h == 3'b000) begin
                c = (press_cnt[i] == CNT_MAX) ? int'(CNT_MAX) : int'(press_cnt[i]) + 1;
                first = (btn_phase[i] == PH_RELEASED);
                if (i == 0) begin
                    if (btn_phase[i] == PH_LONG) begin
                        // In long-held the count measures ticks since the last repeat.
                        if (c >= rp_eff) begin
                            r.rep = 1'b1;
                            c = 0;
                        end
                    end else if (c >= lp_eff - 1) begin
                        // Reaching the threshold on the very first stable tick fires
                        // only the repeat event, with no press event.
                        btn_phase[i] = PH_LONG;
                        r.rep = 1'b1;
                        c = 0;
                        first = 1'b0;
                    end else begin
                        btn_phase[i] = PH_PRESSED;
                    end
                end else begin
                    // Buttons other than button 0 park their count at two.
                    btn_phase[i] = PH_PRESSED;
                    c = 2;
                end
                press_cnt[i] = 16'(c);
                if (first) r.press[i] = 1'b1;
            end
            // Disagreeing samples leave count and phase untouched.
            if (btn_phase[i] != PH_RELEASED) r.held[i] = 1'b1;
        end
        r.lng = (btn_phase[0] == PH_LONG);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    function automatic tick_res_t want_of(logic [4:0] press, logic rep, logic [4:0] held,
                                          logic lng);
        return '{lng: lng, held: held, rep: rep, press: press};
    endfunction

    function automatic dir_row_t tick_row(logic [4:0] levels);
        return '{kind: ROW_TICK, idx: '0, val: {11'd0, levels}, pinned: 1'b0, want: '0};
    endfunction

    function automatic dir_row_t pinned_row(logic [4:0] levels, tick_res_t want);
        return '{kind: ROW_TICK, idx: '0, val: {11'd0, levels}, pinned: 1'b1, want: want};
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
        return '{kind: ROW_CFG, idx: idx, val: val, pinned: 1'b0, want: '0};
    endfunction

    // Scoreboard. Everything is sampled at the rising edge, before the block's own
    // nonblocking updates land, so the values seen are the ones the block acted on.
    always @(posedge aclk) begin
        tick_res_t got;
        tick_res_t want;
        tick_res_t pred;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = tick_res_t'(m_tdata[11:0]);
                if (result_q.size() == 0) begin
                    report_mismatch("result transaction with nothing expected",
                                    int'(got), 0);
                end else begin
                    want = result_q.pop_front();
                    if (got.press !== want.press)
                        report_mismatch("press_events", int'(got.press), int'(want.press));
                    if (got.rep !== want.rep)
                        report_mismatch("repeat_event", int'(got.rep), int'(want.rep));
                    if (got.held !== want.held)
                        report_mismatch("held_buttons", int'(got.held), int'(want.held));
                    if (got.lng !== want.lng)
                        report_mismatch("long_held", int'(got.lng), int'(want.lng));
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_LONG_PRESS_TICKS) lp_reg = cfg_data;
                else if (cfg_index == CFG_REPEAT_TICKS) rp_reg = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                // The predictor always runs so that its state stays in step, even when
                // a hand-typed expectation takes its place.
                pred = debounce_tick(s_tdata[4:0]);
                result_q.push_back(pin_now ? pin_res : pred);
            end
        end
    end

    // Offers one tick, entered and left at a falling edge. Now and then the sender
    // first pauses for a random burst of cycles.
    task automatic send_tick(logic [4:0] levels, bit pin, tick_res_t want);
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, levels};
        pin_now  <= pin;
        pin_res  <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Registers change only while the block is idle. Every tick yields a result, so an
    // empty expectation queue means nothing is in flight.
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Receiver. It alternates ready and stalled bursts. On request it holds off for a
    // long stretch so that both pipeline registers fill and s_tready drops.
    initial begin
        @(negedge aclk);
        forever begin
            if (stall_req) begin
                m_tready <= 1'b0;
                repeat (200) @(negedge aclk);
                stall_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
        end
    end

    // Main sequence: reset, directed rows, then random phases under several settings.
    initial begin
        dir_row_t    rows[$];
        logic [15:0] lp_list [NUM_PHASES];
        logic [15:0] rp_list [NUM_PHASES];
        logic [4:0]  base;
        logic [4:0]  flip;
        int          sent;
        int          len;
        int          pick;
        int          guard;
        bit          stall_done;

        // Settings per random phase, from the reset values through both extremes. The
        // value zero exercises the clamping of out-of-range registers.
        lp_list = '{16'd100, 16'd2, 16'd5, 16'd0, 16'd12, 16'd3, 16'd40, 16'hFFFF, 16'd8};
        rp_list = '{16'd20, 16'd1, 16'd2, 16'd0, 16'd7, 16'hFFFF, 16'd1, 16'hFFFF, 16'd3};
        stall_done = 1'b0;

        for (int i = 0; i < NB; i++) begin
            samp_hist[i] = 3'b111;
            press_cnt[i] = '0;
            btn_phase[i] = PH_RELEASED;
        end
        lp_reg = 16'd100;
        rp_reg = 16'd20;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Under the reset settings: all released, a full press with its
        // one-shot events, unstable samples on alternating bits, and a full release.
        rows.push_back(pinned_row(5'h1F, want_of(5'h00, 1'b0, 5'h00, 1'b0)));
        rows.push_back(pinned_row(5'h00, want_of(5'h00, 1'b0, 5'h00, 1'b0)));
        rows.push_back(pinned_row(5'h00, want_of(5'h00, 1'b0, 5'h00, 1'b0)));
        rows.push_back(pinned_row(5'h00, want_of(5'h1F, 1'b0, 5'h1F, 1'b0)));
        rows.push_back(pinned_row(5'h00, want_of(5'h00, 1'b0, 5'h1F, 1'b0)));
        rows.push_back(pinned_row(5'h15, want_of(5'h00, 1'b0, 5'h1F, 1'b0)));
        rows.push_back(pinned_row(5'h0A, want_of(5'h00, 1'b0, 5'h1F, 1'b0)));
        rows.push_back(tick_row(5'h1F));
        rows.push_back(tick_row(5'h1F));
        rows.push_back(pinned_row(5'h1F, want_of(5'h00, 1'b0, 5'h00, 1'b0)));
        // Threshold below its minimum and repeat of zero: button 0 goes long held on
        // its first stable tick with a repeat event and no press event, then repeats
        // on every tick.
        rows.push_back(cfg_row(CFG_LONG_PRESS_TICKS, 16'd0));
        rows.push_back(cfg_row(CFG_REPEAT_TICKS, 16'd0));
        rows.push_back(tick_row(5'h1E));
        rows.push_back(tick_row(5'h1E));
        rows.push_back(pinned_row(5'h1E, want_of(5'h00, 1'b1, 5'h01, 1'b1)));
        rows.push_back(tick_row(5'h1E));
        rows.push_back(tick_row(5'h1F));
        rows.push_back(tick_row(5'h1F));
        rows.push_back(tick_row(5'h1F));
        // Both registers at their maximum.
        rows.push_back(cfg_row(CFG_LONG_PRESS_TICKS, 16'hFFFF));
        rows.push_back(cfg_row(CFG_REPEAT_TICKS, 16'hFFFF));
        rows.push_back(tick_row(5'h00));
        rows.push_back(tick_row(5'h00));
        rows.push_back(tick_row(5'h00));
        rows.push_back(tick_row(5'h00));
        // Lowering the threshold while button 0 is already pressed pushes it straight
        // into long held; repeats then follow every third tick.
        rows.push_back(cfg_row(CFG_LONG_PRESS_TICKS, 16'd1));
        rows.push_back(cfg_row(CFG_REPEAT_TICKS, 16'd3));
        rows.push_back(tick_row(5'h00));
        rows.push_back(tick_row(5'h00));
        rows.push_back(tick_row(5'h00));
        rows.push_back(tick_row(5'h00));

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) write_reg(rows[k].idx, rows[k].val);
            else send_tick(rows[k].val[4:0], rows[k].pinned, rows[k].want);
        end

        // Random part. Most stimulus is stable holds of a random button pattern, long
        // enough at times to cross the long-press threshold and several repeats. The
        // rest is pure bounce and chatter on single buttons around a held pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_LONG_PRESS_TICKS, lp_list[ph]);
            write_reg(CFG_REPEAT_TICKS, rp_list[ph]);
            // The last phase runs at full rate on both sides.
            if (ph == NUM_PHASES - 1) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (ph == 1 && sent >= PHASE_ITEMS / 2 && !stall_done) begin
                    stall_req  = 1'b1;
                    stall_done = 1'b1;
                end
                base = 5'($urandom_range(0, 31));
                // Button 0 carries the long-press logic, so it is pressed more often.
                if ($urandom_range(0, 9) < 6) base[0] = 1'b0;
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: len = $urandom_range(1, 12);
                        5, 6, 7:       len = $urandom_range(13, 40);
                        default:       len = $urandom_range(41, 160);
                    endcase
                    repeat (len) send_tick(base, 1'b0, '0);
                end else if (pick < 9) begin
                    len = $urandom_range(1, 6);
                    repeat (len) send_tick(5'($urandom_range(0, 31)), 1'b0, '0);
                end else begin
                    len = $urandom_range(4, 20);
                    repeat (len) begin
                        flip = ($urandom_range(0, 3) == 0) ?
                               5'(1 << $urandom_range(0, NB - 1)) : 5'd0;
                        send_tick(base ^ flip, 1'b0, '0);
                    end
                end
                sent += len;
            end
        end

        // Drain: wait for every expected result, then watch for stray result transactions.
        s_tvalid <= 1'b0;
        guard = 0;
        while (result_q.size() != 0 && guard < 10000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (4) @(negedge aclk);
        if (result_q.size() != 0)
            report_mismatch("result transactions never delivered", result_q.size(), 0);

        if (err_count == 0) begin
            $display("PASS button_debounce_long_press");
        end else begin
            $display("FAIL button_debounce_long_press");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("FAIL button_debounce_long_press");
        $finish;
    end

endmodule
